### rtl/tlch_pkg.sv
package tlch_pkg;

   // Default sizes, handed down from the top level
   localparam int MAX_TOKEN_BIN_DEF = 30;
   localparam int CHAR_BINS_DEF     = 128;
   localparam int COUNT_WIDTH_DEF   = 32;

   // Field widths fixed by the stream format
   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 7;
   localparam int REQ_DATA_W = 24;
   localparam int OUT_W      = 32;

   // Address fields sized for the largest allowed bin counts
   localparam int LEN_ADDR_W = 6;
   localparam int CHR_ADDR_W = 8;

   // Command queue between front and back
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_TEXT   = 2'd0,
      OP_RD_LEN = 2'd1,
      OP_RD_CHR = 2'd2,
      OP_NONE   = 2'd3
   } tlch_op_type;

   // One decoded item as the back end executes it
   typedef struct packed {
      logic                  len_bump;
      logic                  chr_bump;
      logic                  rd;
      logic                  rd_chr;
      logic                  rd_zero;
      logic [LEN_ADDR_W-1:0] len_addr;
      logic [CHR_ADDR_W-1:0] chr_addr;
   } tlch_cmd_type;

   function automatic logic tlch_is_sep(input logic [BYTE_W-1:0] b);
      logic sep;
      unique case (b)
         8'h00, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D,
         8'h2C, 8'h3B, 8'h22, 8'h20, 8'h0A, 8'h09, 8'h5E: sep = 1'b1;
         default:                                        sep = 1'b0;
      endcase
      return sep;
   endfunction

endpackage

### rtl/tlch_front.sv
module tlch_front import tlch_pkg::*; #(
   parameter int MAX_TOKEN_BIN = MAX_TOKEN_BIN_DEF,
   parameter int CHAR_BINS     = CHAR_BINS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [OP_W-1:0]    op,
   input  logic [BYTE_W-1:0]  byte_value,
   input  logic               end_of_line,
   input  logic [INDEX_W-1:0] bin_index,
   input  logic               fifo_full,
   output logic               push,
   output tlch_cmd_type       push_cmd
);

   localparam int TLW = $clog2(MAX_TOKEN_BIN + 1);

   logic [TLW-1:0] token_len_ff, token_len_in;
   logic [TLW-1:0] grown, after_byte, close_len;
   logic           accept, sep;
   tlch_op_type    op_code;

   assign req_tready = !fifo_full && !reset;
   assign accept     = req_tvalid && req_tready;
   assign op_code    = tlch_op_type'(op);
   assign sep        = tlch_is_sep(byte_value);

   always_comb begin
      grown      = (token_len_ff < TLW'(MAX_TOKEN_BIN)) ? token_len_ff + TLW'(1) : token_len_ff;
      after_byte = sep ? '0 : grown;
      // a separator closes the open token; end of line closes what the byte left
      close_len  = sep ? token_len_ff : (end_of_line ? after_byte : '0);

      push_cmd = '0;
      push     = 1'b0;
      token_len_in = token_len_ff;
      unique case (op_code)
         OP_TEXT: begin
            push              = accept;
            push_cmd.len_bump = (close_len != '0);
            push_cmd.len_addr = LEN_ADDR_W'(close_len - TLW'(1));
            push_cmd.chr_bump = (byte_value > 8'd1) &&
                                ({1'b0, byte_value} < 9'(CHAR_BINS));
            push_cmd.chr_addr = CHR_ADDR_W'(byte_value);
            if (accept) begin
               token_len_in = (sep || end_of_line) ? '0 : grown;
            end
         end
         OP_RD_LEN: begin
            push              = accept;
            push_cmd.rd       = 1'b1;
            push_cmd.rd_zero  = (bin_index == '0) || (bin_index > INDEX_W'(MAX_TOKEN_BIN));
            push_cmd.len_addr = LEN_ADDR_W'(bin_index - INDEX_W'(1));
         end
         OP_RD_CHR: begin
            push              = accept;
            push_cmd.rd       = 1'b1;
            push_cmd.rd_chr   = 1'b1;
            push_cmd.rd_zero  = ({2'b0, bin_index} >= 9'(CHAR_BINS));
            push_cmd.chr_addr = CHR_ADDR_W'(bin_index);
         end
         OP_NONE: begin
            push = 1'b0;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_len_ff <= '0;
      end else begin
         token_len_ff <= token_len_in;
      end
   end

endmodule

### rtl/tlch_fifo.sv
module tlch_fifo import tlch_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tlch_cmd_type push_cmd,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output tlch_cmd_type head_cmd
);

   tlch_cmd_type           entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_pop;

   assign full       = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/tlch_back.sv
module tlch_back import tlch_pkg::*; #(
   parameter int MAX_TOKEN_BIN = MAX_TOKEN_BIN_DEF,
   parameter int CHAR_BINS     = CHAR_BINS_DEF,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  tlch_cmd_type     head_cmd,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata
);

   localparam int LAW = $clog2(MAX_TOKEN_BIN);
   localparam int CHW = $clog2(CHAR_BINS);

   logic [COUNT_WIDTH-1:0] len_mem [MAX_TOKEN_BIN];
   logic [COUNT_WIDTH-1:0] chr_mem [CHAR_BINS];
   logic [MAX_TOKEN_BIN-1:0] len_vld_ff;
   logic [CHAR_BINS-1:0]     chr_vld_ff;

   logic                   s1_valid_ff;
   tlch_cmd_type           s1_cmd_ff;
   logic [COUNT_WIDTH-1:0] len_rd_ff, chr_rd_ff, len_last_ff, chr_last_ff;
   logic                   len_rv_ff, chr_rv_ff, len_fwd_ff, chr_fwd_ff;
   logic                   rsp_valid_ff;
   logic [OUT_W-1:0]       rsp_data_ff;

   logic [COUNT_WIDTH-1:0] len_cur, chr_cur, len_new, chr_new, rd_val;
   logic [OUT_W-1:0]       rd_clip;
   logic [LAW-1:0]         s1_la, hd_la;
   logic [CHW-1:0]         s1_ca, hd_ca;
   logic                   len_we, chr_we, s1_is_rd, out_free, s1_adv;

   assign s1_la = s1_cmd_ff.len_addr[LAW-1:0];
   assign s1_ca = s1_cmd_ff.chr_addr[CHW-1:0];
   assign hd_la = head_cmd.len_addr[LAW-1:0];
   assign hd_ca = head_cmd.chr_addr[CHW-1:0];

   // take the value just written when the bin was read in the same cycle
   assign len_cur = len_fwd_ff ? len_last_ff : (len_rv_ff ? len_rd_ff : '0);
   assign chr_cur = chr_fwd_ff ? chr_last_ff : (chr_rv_ff ? chr_rd_ff : '0);
   assign len_new = (&len_cur) ? len_cur : len_cur + COUNT_WIDTH'(1);
   assign chr_new = (&chr_cur) ? chr_cur : chr_cur + COUNT_WIDTH'(1);

   assign len_we   = s1_valid_ff && s1_cmd_ff.len_bump;
   assign chr_we   = s1_valid_ff && s1_cmd_ff.chr_bump;
   assign s1_is_rd = s1_valid_ff && s1_cmd_ff.rd;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_adv   = !s1_is_rd || out_free;
   assign pop      = head_valid && s1_adv;

   assign rd_val = s1_cmd_ff.rd_zero ? '0 : (s1_cmd_ff.rd_chr ? chr_cur : len_cur);

   generate
      if (COUNT_WIDTH > OUT_W) begin : g_clip
         assign rd_clip = (|rd_val[COUNT_WIDTH-1:OUT_W]) ? '1 : rd_val[OUT_W-1:0];
      end else begin : g_ext
         assign rd_clip = OUT_W'(rd_val);
      end
   endgenerate

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_vld_ff   <= '0;
         chr_vld_ff   <= '0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= pop;
         end
         if (s1_is_rd && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (len_we) begin
            len_vld_ff[s1_la] <= 1'b1;
         end
         if (chr_we) begin
            chr_vld_ff[s1_ca] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_cmd_ff  <= head_cmd;
         len_rd_ff  <= len_mem[hd_la];
         chr_rd_ff  <= chr_mem[hd_ca];
         len_rv_ff  <= len_vld_ff[hd_la];
         chr_rv_ff  <= chr_vld_ff[hd_ca];
         len_fwd_ff <= len_we && (hd_la == s1_la);
         chr_fwd_ff <= chr_we && (hd_ca == s1_ca);
      end
      if (len_we) begin
         len_last_ff <= len_new;
      end
      if (chr_we) begin
         chr_last_ff <= chr_new;
      end
      if (s1_is_rd && out_free) begin
         rsp_data_ff <= rd_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[s1_la] <= len_new;
      end
   end

   always_ff @(posedge clock) begin
      if (chr_we) begin
         chr_mem[s1_ca] <= chr_new;
      end
   end

endmodule

### rtl/token_length_and_char_histogram.sv
// Token-length and character histogram over a byte stream. Each text item
// (op 0) carries one byte; separators ({ } ( ) [ ] , ; " space newline tab ^
// and byte 0) and tlast (end of line, applied after the byte) close the open
// token, and each closed non-empty token bumps the bin of its length, with
// tokens longer than MAX_TOKEN_BIN counted in the last bin. Bytes 2 up to
// CHAR_BINS-1 bump their own character bin. All counters saturate. A read
// item (op 1 length bin 1..MAX_TOKEN_BIN, op 2 character bin) returns one
// count on the rsp channel, clipped to 32 bits, zero for an out-of-range
// index; op 3 is dropped. Rate: one item per cycle sustained while the result
// channel is not stalled. A read passes the command queue, the bin read and
// the output register before rsp_tvalid rises. Back-to-back updates of the
// same bin are forwarded, so the read-modify-write of the bin stores never
// slows the stream.
// Bins come out of reset empty at once (per-bin valid bits, no clear pass).
module token_length_and_char_histogram import tlch_pkg::*; #(
   parameter int MAX_TOKEN_BIN = MAX_TOKEN_BIN_DEF,
   parameter int CHAR_BINS     = CHAR_BINS_DEF,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // op[1:0], byte_value[9:2], bin_index[16:10]
   input  logic                  req_tlast,   // end_of_line
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata    // bin_count[31:0]
);

   logic         fifo_full, push, pop, head_valid;
   tlch_cmd_type push_cmd, head_cmd;

   // Front: classify bytes, track the open token, turn items into commands
   tlch_front #(
      .MAX_TOKEN_BIN (MAX_TOKEN_BIN),
      .CHAR_BINS     (CHAR_BINS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .op          (req_tdata[1:0]),
      .byte_value  (req_tdata[9:2]),
      .end_of_line (req_tlast),
      .bin_index   (req_tdata[16:10]),
      .fifo_full   (fifo_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Queue: decouple front from a stalled result channel
   tlch_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back: bump and read the bin stores, drive the result register
   tlch_back #(
      .MAX_TOKEN_BIN (MAX_TOKEN_BIN),
      .CHAR_BINS     (CHAR_BINS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/tlch_checker.sv
module tlch_checker import tlch_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_W-1:0]      rsp_tdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // take no item while in reset
   a_no_take_in_reset: assert property (@(posedge clock)
      reset |-> !req_tready)
      else $error("item taken during reset");

   // no result can reach the port before a first read could pass the queue and bin read
   a_quiet_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result shown too soon after reset");

   // a shown result always carries a defined count
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("result carries unknown bits");

endmodule

bind token_length_and_char_histogram tlch_checker u_tlch_checker (.*);

### tb/tb_top.sv
module tb_top;
   import tlch_pkg::*;

   localparam int CLK_PERIOD  = 12;
   localparam int RESET_TICKS = 8;
   localparam int ITEM_TARGET = 1400;
   localparam int MAX_IDLE    = 17;
   // Drain time after the last read result: queue, bin read, output register
   localparam int DRAIN_TICKS = 20;
   localparam int LIMIT_TICKS = 600_000;

   // One request as queued for the driver. hold: wait for every pending
   // read result before launching this item.
   typedef struct packed {
      logic                hold;
      tlch_op_type         op;
      logic [BYTE_W-1:0]   byte_value;
      logic                eol;
      logic [INDEX_W-1:0]  bin_index;
   } stream_item_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // op[1:0], byte_value[9:2], bin_index[16:10]
   logic                  req_tlast  = 1'b0; // end_of_line
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_W-1:0]      rsp_tdata;         // bin_count[31:0]

   token_length_and_char_histogram u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Mirror of the histogram state, advanced as each item is accepted
   logic [4:0]                 open_len;
   logic [COUNT_WIDTH_DEF-1:0] len_hist [MAX_TOKEN_BIN_DEF];
   logic [COUNT_WIDTH_DEF-1:0] chr_hist [CHAR_BINS_DEF];

   stream_item_type    pending [$];     // items not yet launched
   logic [OUT_W-1:0]   counts_due [$];  // bin counts owed by the block, oldest first
   stream_item_type    on_bus;
   logic               hold_next   = 1'b0;
   int                 work_queued = 0;
   int                 mismatches  = 0;
   int                 send_wait   = 0;
   int                 recv_wait   = 0;
   logic               tx_calm     = 1'b0;
   logic               rx_calm     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic logic is_delim(input logic [BYTE_W-1:0] b);
      case (b)
         8'h00, "{", "}", "(", ")", "[", "]", ",", ";", "\"", " ", "\n", "\t", "^":
            return 1'b1;
         default:
            return 1'b0;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_delim();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (!is_delim(b));
      return b;
   endfunction

   task automatic push_item(input tlch_op_type op, input logic [BYTE_W-1:0] b,
                            input logic eol, input logic [INDEX_W-1:0] idx);
      stream_item_type it;
      it.hold       = hold_next;
      it.op         = op;
      it.byte_value = b;
      it.eol        = eol;
      it.bin_index  = idx;
      pending.push_back(it);
      hold_next = 1'b0;
      if (op != OP_NONE) work_queued++;
   endtask

   // Close the open token: bump its length bin (saturating), then clear it
   task automatic close_token();
      if (open_len != 0 && len_hist[open_len - 1] != '1)
         len_hist[open_len - 1] += 1'b1;
      open_len = '0;
   endtask

   // Apply one accepted item to the mirror; reads queue the count they see
   task automatic tally_item(input stream_item_type it);
      case (it.op)
         OP_TEXT: begin
            if (is_delim(it.byte_value)) close_token();
            else if (open_len < MAX_TOKEN_BIN_DEF) open_len += 1'b1;
            if (it.byte_value > 1 && it.byte_value < CHAR_BINS_DEF &&
                chr_hist[it.byte_value[INDEX_W-1:0]] != '1)
               chr_hist[it.byte_value[INDEX_W-1:0]] += 1'b1;
            // end of line closes the token after the byte itself counted
            if (it.eol) close_token();
         end
         OP_RD_LEN: begin
            if (it.bin_index >= 1 && it.bin_index <= MAX_TOKEN_BIN_DEF)
               counts_due.push_back(OUT_W'(len_hist[it.bin_index - 1]));
            else
               counts_due.push_back('0);
         end
         OP_RD_CHR: counts_due.push_back(OUT_W'(chr_hist[it.bin_index]));
         default: ;  // ignored by the block
      endcase
   endtask

   // Driver: predict on acceptance, then launch the next item after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         open_len = '0;
         foreach (len_hist[k]) len_hist[k] = '0;
         foreach (chr_hist[k]) chr_hist[k] = '0;
      end else begin
         if (req_tvalid && req_tready) tally_item(on_bus);
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (pending.size() != 0 &&
                         !(pending[0].hold && counts_due.size() != 0)) begin
               on_bus = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, on_bus.bin_index, on_bus.byte_value, on_bus.op};
               req_tlast  <= on_bus.eol;
               // flip between idle-free bursts and randomly gapped stretches
               if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
               send_wait = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result against the oldest owed count, then stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (counts_due.size() == 0) begin
               $error("bin_count: expected no item, got %0d", rsp_tdata);
               mismatches++;
            end else begin
               if (rsp_tdata !== counts_due[0]) begin
                  $error("bin_count: expected %0d, got %0d", counts_due[0], rsp_tdata);
                  mismatches++;
               end
               void'(counts_due.pop_front());
            end
            if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
            recv_wait = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int                len;
      int                pick;
      logic [BYTE_W-1:0] b;
      logic [INDEX_W-1:0] idx;
      logic              mid_hold;

      mid_hold = 1'b0;

      // Directed: empty reads, odd bytes inside a token, separators with
      // nothing open, end of line on word and separator bytes, ignored op
      push_item(OP_RD_LEN, 8'hFF, 1'b1, 7'd0);
      push_item(OP_RD_CHR, 8'h00, 1'b0, 7'd127);
      push_item(OP_TEXT,   "a",   1'b0, 7'd127);
      push_item(OP_NONE,   "q",   1'b1, 7'd5);   // must not close the token
      push_item(OP_TEXT,   8'hFF, 1'b0, 7'd0);
      push_item(OP_TEXT,   8'h80, 1'b0, 7'd0);
      push_item(OP_TEXT,   8'h01, 1'b0, 7'd0);
      push_item(OP_TEXT,   8'h00, 1'b0, 7'd0);   // closes a 4-byte token
      push_item(OP_TEXT,   " ",   1'b0, 7'd0);
      push_item(OP_TEXT,   "x",   1'b1, 7'd0);
      push_item(OP_TEXT,   ";",   1'b1, 7'd0);
      push_item(OP_TEXT,   8'h7F, 1'b0, 7'd0);
      push_item(OP_TEXT,   8'h02, 1'b1, 7'd0);
      push_item(OP_RD_LEN, 8'h00, 1'b0, 7'd1);
      push_item(OP_RD_LEN, 8'h00, 1'b0, 7'd2);
      push_item(OP_RD_LEN, 8'h00, 1'b0, 7'd4);
      push_item(OP_RD_LEN, 8'h00, 1'b0, 7'd30);
      push_item(OP_RD_LEN, 8'h00, 1'b0, 7'd31);
      push_item(OP_RD_LEN, 8'h00, 1'b0, 7'd127);
      push_item(OP_RD_CHR, 8'h00, 1'b0, 7'd0);
      push_item(OP_RD_CHR, 8'h00, 1'b0, 7'd1);
      push_item(OP_RD_CHR, 8'h00, 1'b0, 7'd2);
      push_item(OP_RD_CHR, 8'h00, 1'b0, 7'h61);
      push_item(OP_RD_CHR, 8'h00, 1'b0, 7'd127);

      // Random: mostly words with separators between them, plus reads
      hold_next = 1'b1;
      while (work_queued < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick == 0) hold_next = 1'b1;
         if (pick < 55) begin
            // word; a few long enough to hit the capped last bin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 45)
                                              : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 1) == 0)
                  b = BYTE_W'($urandom_range(8'h61, 8'h7A));
               else
                  do b = BYTE_W'($urandom_range(0, 255)); while (is_delim(b));
               push_item(OP_TEXT, b, 1'b0, INDEX_W'($urandom));
            end
            // end the word: separator, end of line, or run into the next one
            case ($urandom_range(0, 9))
               0:       ;
               1, 2:    pending[$].eol = 1'b1;
               default: push_item(OP_TEXT, pick_delim(), 1'($urandom),
                                  INDEX_W'($urandom));
            endcase
         end else if (pick < 80) begin
            if ($urandom_range(0, 2) != 0) begin
               idx = ($urandom_range(0, 7) == 0) ? INDEX_W'($urandom)
                                                 : INDEX_W'($urandom_range(1, 30));
               push_item(OP_RD_LEN, BYTE_W'($urandom), 1'($urandom), idx);
            end else begin
               idx = ($urandom_range(0, 1) == 0) ? INDEX_W'($urandom)
                                                 : INDEX_W'($urandom_range(8'h61, 8'h7A));
               push_item(OP_RD_CHR, BYTE_W'($urandom), 1'($urandom), idx);
            end
         end else if (pick < 85) begin
            push_item(OP_NONE, BYTE_W'($urandom), 1'($urandom), INDEX_W'($urandom));
         end else if (pick < 95) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
               push_item(OP_TEXT, pick_delim(), ($urandom_range(0, 4) == 0),
                         INDEX_W'($urandom));
         end else begin
            push_item(OP_TEXT, BYTE_W'($urandom), 1'($urandom), INDEX_W'($urandom));
         end
         // pause the sender mid-run until every owed count is back
         if (!mid_hold && work_queued >= ITEM_TARGET / 2) begin
            hold_next = 1'b1;
            mid_hold  = 1'b1;
         end
      end
      // read every bin once at the end
      for (int k = 0; k <= MAX_TOKEN_BIN_DEF + 1; k++)
         push_item(OP_RD_LEN, 8'h00, 1'b0, INDEX_W'(k));
      for (int k = 0; k < CHAR_BINS_DEF; k++)
         push_item(OP_RD_CHR, 8'h00, 1'b0, INDEX_W'(k));

      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // hold until every item is accepted and every count has come back
      while (pending.size() != 0 || req_tvalid) @(posedge clock);
      while (counts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Timeout far beyond the slowest legal run
   initial begin
      #(CLK_PERIOD * LIMIT_TICKS);
      $display("Verification failed");
      $finish;
   end

endmodule
